// ===== sv/oaht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam logic [31:0] GOLDEN_Q32 = 32'h9E3779B9;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, start hash
      logic hash_mul;  // register hash fraction
      logic hash_home; // register home slot, issue first read
      logic advance;   // step to next slot and read it
      logic write_ins; // write insert at current slot
      logic write_del; // tombstone current slot
      logic respond;   // drive result
      logic [1:0] rsp_status;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic occupied;
      logic tombstone;
      logic key_match;
      logic last_probe;
      logic clearing;  // flag clear pass after reset still running
   } stat_type;

endpackage
`default_nettype wire

// ===== sv/oaht_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_datapath
// Request registers, hash, slot memories, probe index and result registers.
// ----------------------------------------------------------------------------
module oaht_datapath #(
   parameter int SLOTS       = 256,
   parameter int KEY_CHARS   = 8,
   parameter int HASH_CHARS  = 8,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX_W       = $clog2(SLOTS),
   parameter int SIZE_W      = $clog2(SLOTS + 1)
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire oaht_pkg::ctrl_type ctrl,
   output oaht_pkg::stat_type      stat,
   input  wire [1:0]              req_cmd,
   input  wire [8*KEY_CHARS-1:0]  req_key_bytes,
   input  wire [3:0]              req_key_length,
   input  wire [VALUE_WIDTH-1:0]  req_value_in,
   input  wire                    csr_we,
   input  wire [8:0]              csr_wdata,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [VALUE_WIDTH-1:0] rsp_value_out,
   output logic [7:0]             rsp_slot
);
   import oaht_pkg::*;

   localparam int KW = 8 * KEY_CHARS;
   localparam logic [3:0] KC = 4'(KEY_CHARS);
   localparam logic [3:0] HC = 4'(HASH_CHARS);

   // table size register
   logic [8:0] size_ff;
   always_ff @(posedge clock) begin
      if (reset) size_ff <= 9'd256;
      else if (csr_we) size_ff <= csr_wdata;
   end

   // live size: zero reads as one, saturate at SLOTS
   logic [SIZE_W-1:0] ts;
   always_comb begin
      if (size_ff == 9'd0) ts = SIZE_W'(1);
      else if ({23'd0, size_ff} > 32'(SLOTS)) ts = SIZE_W'(SLOTS);
      else ts = SIZE_W'(size_ff);
   end

   // request capture with length saturation and key masking
   logic [1:0]       cmd_ff;
   logic [KW-1:0]    key_ff;
   logic [3:0]       len_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [31:0]      sum_ff;
   logic [3:0]       len_sat;
   logic [KW-1:0]    key_msk;
   logic [3:0]       hn;
   logic [31:0]      sum_c;
   always_comb begin
      len_sat = (req_key_length > KC) ? KC : req_key_length;
      hn      = (len_sat < HC) ? len_sat : HC;
      for (int i = 0; i < KEY_CHARS; i++)
         key_msk[8*i +: 8] = (4'(i) < len_sat) ? req_key_bytes[8*i +: 8] : 8'd0;
      sum_c = 32'd0;
      for (int i = 0; i < HASH_CHARS; i++)
         if (4'(i) < hn)
            sum_c = sum_c + 32'(signed'(key_msk[8*i +: 8])) * 32'(i + 1);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         key_ff <= key_msk;
         len_ff <= len_sat;
         val_ff <= req_value_in;
         sum_ff <= sum_c;
      end
   end

   // hash: fraction then scale
   logic [31:0] frac_ff;
   logic [31:0] frac_c;
   logic [63:0] gprod;
   logic [31:0] home_c;
   assign gprod  = 64'(sum_ff) * 64'(GOLDEN_Q32);
   assign frac_c = gprod[31:0];
   assign home_c = 32'((64'(frac_ff) * 64'(ts)) >> 32);
   always_ff @(posedge clock) begin
      if (ctrl.hash_mul) frac_ff <= frac_c;
   end

   // probe index and count
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SIZE_W-1:0] cnt_ff;
   logic [SIZE_W:0]   idx_inc;
   assign idx_inc = (SIZE_W+1)'(idx_ff) + (SIZE_W+1)'(1);
   always_comb begin
      idx_in = idx_ff;
      if (ctrl.hash_home) idx_in = IDX_W'(home_c);
      else if (ctrl.advance)
         idx_in = (idx_inc >= (SIZE_W+1)'(ts)) ? '0 : idx_inc[IDX_W-1:0];
   end
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (ctrl.hash_home) cnt_ff <= SIZE_W'(1);
      else if (ctrl.advance) cnt_ff <= cnt_ff + SIZE_W'(1);
   end

   // slot memories (contents undefined until written)
   logic [KW-1:0]          key_mem [SLOTS];
   logic [3:0]             len_mem [SLOTS];
   logic [VALUE_WIDTH-1:0] val_mem [SLOTS];
   logic [KW-1:0]          rd_key_ff;
   logic [3:0]             rd_len_ff;
   logic [VALUE_WIDTH-1:0] rd_val_ff;
   always_ff @(posedge clock) begin
      if (ctrl.write_ins) begin
         key_mem[idx_ff] <= key_ff;
         len_mem[idx_ff] <= len_ff;
         val_mem[idx_ff] <= val_ff;
      end
      rd_key_ff <= key_mem[idx_in];
      rd_len_ff <= len_mem[idx_in];
      rd_val_ff <= val_mem[idx_in];
   end

   // clear pass over the flag memory, one slot per cycle after reset
   logic             clr_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == IDX_W'(SLOTS - 1)) clr_ff <= 1'b0;
      end
   end

   // flag memory: bit 1 occupied, bit 0 tombstone
   logic [1:0] flag_mem [SLOTS];
   logic [1:0] rd_flag_ff;
   always_ff @(posedge clock) begin
      if (clr_ff) flag_mem[clr_idx_ff] <= 2'b00;
      else if (ctrl.write_ins) flag_mem[idx_ff] <= {1'b1, 1'b0};
      else if (ctrl.write_del) flag_mem[idx_ff] <= {1'b0, 1'b1};
      rd_flag_ff <= flag_mem[idx_in];
   end

   assign stat.cmd        = cmd_ff;
   assign stat.occupied   = rd_flag_ff[1];
   assign stat.tombstone  = rd_flag_ff[0];
   assign stat.key_match  = (rd_len_ff == len_ff) && (rd_key_ff == key_ff);
   assign stat.last_probe = (cnt_ff >= ts);
   assign stat.clearing   = clr_ff;

   // result registers
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= ctrl.respond;
      if (ctrl.respond) begin
         rsp_status <= ctrl.rsp_status;
         rsp_slot   <= (ctrl.rsp_status == ST_DONE) ? 8'(idx_ff) : 8'd0;
         rsp_value_out <= (ctrl.rsp_status == ST_DONE && cmd_ff == CMD_LOOKUP)
                          ? rd_val_ff : '0;
      end
   end

endmodule
`default_nettype wire

// ===== sv/oaht_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: hash, probe one slot per cycle, write back, respond.
// ----------------------------------------------------------------------------
module oaht_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire oaht_pkg::stat_type  stat,
   output oaht_pkg::ctrl_type       ctrl
);
   import oaht_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_HOME, S_PROBE, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] st_ff, st_in;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      ctrl     = '0;
      ctrl.rsp_status = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !stat.clearing) begin
               ctrl.load = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            ctrl.hash_mul = 1'b1;
            state_in = S_HOME;
         end
         S_HOME: begin
            ctrl.hash_home = 1'b1;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            state_in = S_RESP;
            if (stat.cmd == CMD_INSERT) begin
               if (!stat.occupied || stat.key_match) begin
                  ctrl.write_ins = 1'b1;
                  st_in = ST_DONE;
               end else if (stat.last_probe) st_in = ST_FULL;
               else begin
                  ctrl.advance = 1'b1;
                  state_in = S_PROBE;
               end
            end else if (stat.cmd == CMD_LOOKUP || stat.cmd == CMD_DELETE) begin
               if (!stat.occupied && !stat.tombstone) st_in = ST_NOT_FOUND;
               else if (stat.occupied && stat.key_match) begin
                  ctrl.write_del = (stat.cmd == CMD_DELETE);
                  st_in = ST_DONE;
               end else if (stat.last_probe) st_in = ST_NOT_FOUND;
               else begin
                  ctrl.advance = 1'b1;
                  state_in = S_PROBE;
               end
            end else st_in = ST_NOT_FOUND;
         end
         S_RESP: begin
            ctrl.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_NOT_FOUND;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   assign busy = (state_ff != S_IDLE) || stat.clearing;

   // a write only happens while probing
   a_wr_probe: assert property (@(posedge clock) disable iff (reset)
      (ctrl.write_ins || ctrl.write_del) |-> state_ff == S_PROBE)
      else $error("write outside probe");
   // insert and delete never together
   a_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.write_ins && ctrl.write_del))
      else $error("write conflict");
   // respond follows a finished probe
   a_resp: assert property (@(posedge clock) disable iff (reset)
      ctrl.respond |-> $past(state_ff) == S_PROBE)
      else $error("respond without probe");
   // no request taken while the flag clear pass runs
   a_no_load_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !ctrl.load)
      else $error("request taken during clear");
endmodule
`default_nettype wire

// ===== sv/open_addressing_hash_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// Linear-probing key/value table with tombstones.
// ----------------------------------------------------------------------------
// Sequence: capture, hash fraction, home slot, then P slots probed (1 up to the
// live slot count), then the registered response; busy until back in idle. The
// probe walks one slot per cycle through the slot memory read port.
// Reset: synchronous; slot count returns to 256, then a pass over all slots clears
// the occupied and tombstone flags with busy high. Results strobe for one cycle.
module open_addressing_hash_table_core #(
   parameter int SLOTS       = 256,
   parameter int KEY_CHARS   = 8,
   parameter int HASH_CHARS  = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire [1:0]              req_cmd,
   input  wire [8*KEY_CHARS-1:0]  req_key_bytes,
   input  wire [3:0]              req_key_length,
   input  wire [VALUE_WIDTH-1:0]  req_value_in,
   input  wire                    csr_we,
   input  wire [8:0]              csr_wdata,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [VALUE_WIDTH-1:0] rsp_value_out,
   output logic [7:0]             rsp_slot
);
   import oaht_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   oaht_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .ctrl(ctrl)
   );

   oaht_datapath #(
      .SLOTS(SLOTS), .KEY_CHARS(KEY_CHARS),
      .HASH_CHARS(HASH_CHARS), .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_cmd(req_cmd), .req_key_bytes(req_key_bytes),
      .req_key_length(req_key_length), .req_value_in(req_value_in),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out), .rsp_slot(rsp_slot)
   );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the open-addressing hash table core. A predictor
// tracks slot contents, occupied and tombstone flags, and checks every
// response beat in order against the predicted status, value and slot.
// ----------------------------------------------------------------------------
module tb_top;
   import oaht_pkg::*;

   // command code outside the defined set
   localparam logic [1:0] CMD_ILLEGAL = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
      logic [7:0]  slot;
   } rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [63:0] req_key_bytes;
   logic [3:0]  req_key_length;
   logic [31:0] req_value_in;
   logic        csr_we;
   logic [8:0]  csr_wdata;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic [7:0]  rsp_slot;

   // predictor state
   logic [63:0] pred_key [256];
   logic [3:0]  pred_len [256];
   logic [31:0] pred_val [256];
   logic        pred_occ [256];
   logic        pred_tomb[256];
   logic [8:0]  pred_size;

   rsp_type     expected_rsp[$];
   int          error_count;
   int          beats_sent;
   int          beats_checked;
   int          cycle_count;
   bit          idle_on;
   logic [63:0] key_pool[16];
   logic [3:0]  len_pool[16];

   open_addressing_hash_table_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_key_bytes(req_key_bytes),
      .req_key_length(req_key_length), .req_value_in(req_value_in),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out), .rsp_slot(rsp_slot)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // golden-ratio home slot of a masked key
   function automatic int unsigned home_of(logic [63:0] key, int unsigned len,
                                           int unsigned ts);
      logic signed [31:0] sum;
      logic [63:0] prod;
      logic [31:0] frac;
      logic [40:0] scaled;
      sum = 0;
      for (int i = 0; i < len; i++)
         sum += $signed(key[i*8 +: 8]) * (i + 1);
      prod = {{32{sum[31]}}, sum} * 64'h9E3779B9;
      frac = prod[31:0];
      scaled = ({9'd0, frac} * ts) >> 32;
      return 32'(scaled);
   endfunction

   // compute expected response and update the shadow table
   function automatic rsp_type predict_table(logic [1:0] cmd, logic [63:0] key_in,
                                             logic [3:0] len_in, logic [31:0] val);
      rsp_type r;
      int unsigned len, ts, idx;
      logic [63:0] key;
      bit hit;
      len = (len_in > 8) ? 8 : len_in;
      key = (len >= 8) ? key_in : key_in & ((64'd1 << (len * 8)) - 1);
      ts = (pred_size == 0) ? 1 : (pred_size > 256) ? 256 : pred_size;
      idx = home_of(key, len, ts);
      r = '{status: ST_NOT_FOUND, value: 0, slot: 0};
      hit = 0;
      if (cmd == CMD_INSERT) begin
         for (int i = 0; i < ts && !hit; i++) begin
            if (!pred_occ[idx] || (pred_len[idx] == len && pred_key[idx] == key))
               hit = 1;
            else
               idx = (idx + 1 >= ts) ? 0 : idx + 1;
         end
         if (hit) begin
            pred_key[idx] = key; pred_len[idx] = len; pred_val[idx] = val;
            pred_occ[idx] = 1; pred_tomb[idx] = 0;
            r.status = ST_DONE; r.slot = idx;
         end else
            r.status = ST_FULL;
      end else if (cmd == CMD_LOOKUP || cmd == CMD_DELETE) begin
         for (int i = 0; i < ts && !hit; i++) begin
            if (!pred_occ[idx] && !pred_tomb[idx])
               hit = 1;
            else if (pred_occ[idx] && pred_len[idx] == len && pred_key[idx] == key) begin
               hit = 1;
               r.status = ST_DONE; r.slot = idx;
               if (cmd == CMD_LOOKUP) r.value = pred_val[idx];
               else begin
                  pred_occ[idx] = 0; pred_tomb[idx] = 1;
               end
            end else
               idx = (idx + 1 >= ts) ? 0 : idx + 1;
         end
      end
      return r;
   endfunction

   // random idle burst on the request side
   task automatic maybe_idle();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // send one request beat and record its prediction
   task automatic send_req(logic [1:0] cmd, logic [63:0] key, logic [3:0] len,
                           logic [31:0] val);
      maybe_idle();
      start <= 1;
      req_cmd <= cmd; req_key_bytes <= key; req_key_length <= len;
      req_value_in <= val;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(predict_table(cmd, key, len, val));
      beats_sent++;
   endtask

   // drop start, wait until the table is quiet, then write the slot count
   task automatic set_size(logic [8:0] sz);
      start <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1; csr_wdata <= sz;
      @(posedge clock);
      csr_we <= 0;
      pred_size = sz;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         beats_checked++;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected beat status=%0d value=%h slot=%0d",
                     $time, rsp_status, rsp_value_out, rsp_slot);
            error_count++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               error_count++;
            end
            if (rsp_value_out !== e.value) begin
               $display("%0t: value exp %h got %h", $time, e.value, rsp_value_out);
               error_count++;
            end
            if (rsp_slot !== e.slot) begin
               $display("%0t: slot exp %0d got %0d", $time, e.slot, rsp_slot);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("timeout with %0d beats pending", expected_rsp.size());
         $display("open_addressing_hash_table_core verification failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // extremes of every field, every command, bad command, long/zero keys
   task automatic test_directed();
      send_req(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
      send_req(CMD_INSERT, 64'd0, 4'd0, 32'd0);
      send_req(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(CMD_LOOKUP, 64'h1234, 4'd0, 32'd5);
      send_req(CMD_INSERT, 64'h8080_8080_8080_8080, 4'd15, 32'hA5A5_5A5A);
      send_req(CMD_LOOKUP, 64'h8080_8080_8080_8080, 4'd8, 32'd0);
      send_req(CMD_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 4'd9, 32'h1);
      send_req(CMD_ILLEGAL, 64'h7F7F_7F7F_7F7F_7F7F, 4'd8, 32'h1);
      send_req(CMD_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(CMD_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h55);
      send_req(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h66);
      send_req(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(CMD_DELETE, 64'd0, 4'd0, 32'd0);
   endtask

   // tiny tables: fill, overflow, tombstone reuse, size zero
   task automatic test_small_tables();
      for (int s = 0; s < 4; s++) begin
         set_size(s == 3 ? 9'd5 : s[8:0]);
         for (int k = 0; k < 8; k++)
            send_req(CMD_INSERT, 64'(k * 37 + 3), 4'd2, $urandom);
         send_req(CMD_DELETE, 64'(3), 4'd2, 32'd0);
         send_req(CMD_LOOKUP, 64'(40), 4'd2, 32'd0);
         send_req(CMD_INSERT, 64'(999), 4'd2, $urandom);
         send_req(CMD_LOOKUP, 64'(999), 4'd2, 32'd0);
      end
   endtask

   // random traffic over a pool of keys under several sizes
   task automatic test_random(int n, logic [8:0] sz);
      int pick;
      logic [1:0] cmd;
      set_size(sz);
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = rand_key();
         len_pool[i] = 4'($urandom_range(0, 8));
      end
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 15);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: cmd = CMD_INSERT;
            4, 5, 6:    cmd = CMD_LOOKUP;
            7, 8:       cmd = CMD_DELETE;
            default:    cmd = CMD_ILLEGAL;
         endcase
         if ($urandom_range(0, 7) == 0)
            send_req(cmd, rand_key(), 4'($urandom_range(0, 15)), $urandom);
         else
            send_req(cmd, key_pool[pick] ^ ({$urandom, $urandom} << (len_pool[pick] * 8)),
                     len_pool[pick], $urandom);
      end
   endtask

   initial begin
      reset = 1; start = 0; req_cmd = CMD_INSERT; req_key_bytes = 0;
      req_key_length = 0; req_value_in = 0; csr_we = 0; csr_wdata = 0;
      error_count = 0; beats_sent = 0; beats_checked = 0; cycle_count = 0;
      idle_on = 1; pred_size = 256;
      for (int i = 0; i < 256; i++) begin
         pred_occ[i] = 0; pred_tomb[i] = 0;
         pred_key[i] = 0; pred_len[i] = 0; pred_val[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_small_tables();
      test_random(400, 9'd13);
      test_random(400, 9'd256);
      test_random(300, 9'd2);
      test_random(300, 9'd511);
      idle_on = 0;
      test_random(400, 9'd37);
      start <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d request beats, checked %0d response beats", beats_sent,
               beats_checked);
      $display("covered sizes 0..511, table overflow, tombstones and bad commands");
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("open_addressing_hash_table_core verification clean");
      else
         $display("open_addressing_hash_table_core verification failed");
      $finish;
   end
endmodule
